/* hdl/pgalloc_pkg.sv */
package pgalloc_pkg;

   // Store geometry. PAGE_BYTES must be a power of two: the offset is cut to its low bits.
   localparam int NUM_PAGES  = 64;
   localparam int PAGE_BYTES = 4096;

   localparam int PAGE_W   = $clog2(NUM_PAGES);
   localparam int OFF_W    = $clog2(PAGE_BYTES);
   localparam int STORE_AW = PAGE_W + OFF_W;
   localparam int STORE_DEPTH = NUM_PAGES * PAGE_BYTES;
   localparam int CNT_W    = $clog2(NUM_PAGES + 1);

   // Fixed field widths of the command and result beats.
   localparam int PAGE_ID_W = 6;
   localparam int OFFSET_W  = 12;
   localparam int BYTE_W    = 8;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_WRITE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FREE   = 2'd1,
      ST_NOT_ALLOC = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_DECIDE,
      S_FETCH,
      S_SCAN
   } state_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [PAGE_ID_W-1:0]  page_id;
      logic [OFFSET_W-1:0]   offset;
      logic [BYTE_W-1:0]     write_byte;
      logic                  run_last;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [PAGE_ID_W-1:0]  alloc_page;
      logic [BYTE_W-1:0]     read_byte;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic              rd_en;
      logic [PAGE_W-1:0] rd_addr;
      logic              wr_en;
      logic [PAGE_W-1:0] wr_addr;
      logic              wr_data;
   } map_req_type;

   typedef struct packed {
      logic                en;
      logic                we;
      logic [STORE_AW-1:0] addr;
      logic [BYTE_W-1:0]   wdata;
   } store_req_type;

endpackage

/* hdl/pgalloc_map.sv */
// Used-page bitmap: one write port, one read port, registered read data.
module pgalloc_map (
   input  logic                     clock,
   input  pgalloc_pkg::map_req_type map_req,
   output logic                     rd_data
);

   logic map_mem_ff [pgalloc_pkg::NUM_PAGES];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         map_mem_ff[map_req.wr_addr] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_data_ff <= map_mem_ff[map_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/pgalloc_store.sv */
// Page byte store: single port, registered read data.
module pgalloc_store (
   input  logic                                 clock,
   input  pgalloc_pkg::store_req_type           store_req,
   output logic [pgalloc_pkg::BYTE_W-1:0]       rd_data
);

   logic [pgalloc_pkg::BYTE_W-1:0] store_mem_ff [pgalloc_pkg::STORE_DEPTH];
   logic [pgalloc_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.en) begin
         if (store_req.we) begin
            store_mem_ff[store_req.addr] <= store_req.wdata;
         end else begin
            rd_data_ff <= store_mem_ff[store_req.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/pgalloc_ctrl.sv */
// Command sequencer: bitmap clearing pass, page lookup, next-fit scan and byte access.
module pgalloc_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  pgalloc_pkg::req_type                req_item,
   output logic                                busy,
   output logic                                rsp_valid,
   output pgalloc_pkg::rsp_type                rsp_item,
   output pgalloc_pkg::map_req_type            map_req,
   input  logic                                map_rdata,
   output pgalloc_pkg::store_req_type          store_req,
   input  logic [pgalloc_pkg::BYTE_W-1:0]      store_rdata
);

   pgalloc_pkg::state_type             state_ff, state_in;
   pgalloc_pkg::req_type               cmd_ff, cmd_in;
   logic [pgalloc_pkg::PAGE_W-1:0]     ptr_ff, ptr_in;
   logic [pgalloc_pkg::PAGE_W-1:0]     probe_ff, probe_in;
   logic [pgalloc_pkg::PAGE_W-1:0]     pend_page_ff, pend_page_in;
   logic                               pend_ff, pend_in;
   logic [pgalloc_pkg::CNT_W-1:0]      issued_ff, issued_in;
   logic [pgalloc_pkg::CNT_W-1:0]      checked_ff, checked_in;
   logic [pgalloc_pkg::PAGE_W-1:0]     clr_ff, clr_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   pgalloc_pkg::rsp_type               rsp_ff, rsp_in;

   logic                               in_range;
   logic [pgalloc_pkg::PAGE_W-1:0]     page_idx;
   logic [pgalloc_pkg::OFF_W-1:0]      off_idx;

   localparam logic [pgalloc_pkg::PAGE_W-1:0] LAST_PAGE =
      pgalloc_pkg::PAGE_W'(pgalloc_pkg::NUM_PAGES - 1);

   function automatic logic [pgalloc_pkg::PAGE_W-1:0] next_page(
      input logic [pgalloc_pkg::PAGE_W-1:0] p);
      return (p == LAST_PAGE) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pgalloc_pkg::S_CLEAR;
         ptr_ff       <= '0;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      probe_ff     <= probe_in;
      pend_page_ff <= pend_page_in;
      issued_ff    <= issued_in;
      checked_ff   <= checked_in;
      rsp_ff       <= rsp_in;
   end

   assign in_range = 32'(cmd_ff.page_id) < pgalloc_pkg::NUM_PAGES;
   assign page_idx = pgalloc_pkg::PAGE_W'(cmd_ff.page_id);
   assign off_idx  = pgalloc_pkg::OFF_W'(cmd_ff.offset);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ptr_in       = ptr_ff;
      probe_in     = probe_ff;
      pend_page_in = pend_page_ff;
      pend_in      = 1'b0;
      issued_in    = issued_ff;
      checked_in   = checked_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      map_req      = '0;
      store_req    = '0;

      unique case (state_ff)
         pgalloc_pkg::S_CLEAR: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = clr_ff;
            map_req.wr_data = 1'b0;
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == LAST_PAGE) begin
               state_in = pgalloc_pkg::S_IDLE;
            end
         end
         pgalloc_pkg::S_IDLE: begin
            if (start) begin
               cmd_in = req_item;
               if (req_item.cmd == pgalloc_pkg::CMD_ALLOC) begin
                  probe_in   = ptr_ff;
                  issued_in  = '0;
                  checked_in = '0;
                  state_in   = pgalloc_pkg::S_SCAN;
               end else begin
                  state_in = pgalloc_pkg::S_LOOKUP;
               end
            end
         end
         pgalloc_pkg::S_LOOKUP: begin
            map_req.rd_en   = in_range;
            map_req.rd_addr = page_idx;
            state_in        = pgalloc_pkg::S_DECIDE;
         end
         pgalloc_pkg::S_DECIDE: begin
            rsp_in.status     = pgalloc_pkg::ST_OK;
            rsp_in.alloc_page = '0;
            rsp_in.read_byte  = '0;
            rsp_in.last       = cmd_ff.run_last;
            state_in          = pgalloc_pkg::S_IDLE;
            if (!(in_range && map_rdata)) begin
               rsp_in.status = pgalloc_pkg::ST_NOT_ALLOC;
               rsp_valid_in  = 1'b1;
            end else begin
               unique case (cmd_ff.cmd)
                  pgalloc_pkg::CMD_FREE: begin
                     map_req.wr_en   = 1'b1;
                     map_req.wr_addr = page_idx;
                     map_req.wr_data = 1'b0;
                     rsp_valid_in    = 1'b1;
                  end
                  pgalloc_pkg::CMD_READ: begin
                     store_req.en   = 1'b1;
                     store_req.addr = {page_idx, off_idx};
                     state_in       = pgalloc_pkg::S_FETCH;
                  end
                  pgalloc_pkg::CMD_WRITE: begin
                     store_req.en    = 1'b1;
                     store_req.we    = 1'b1;
                     store_req.addr  = {page_idx, off_idx};
                     store_req.wdata = cmd_ff.write_byte;
                     rsp_valid_in    = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         pgalloc_pkg::S_FETCH: begin
            rsp_in.status     = pgalloc_pkg::ST_OK;
            rsp_in.alloc_page = '0;
            rsp_in.read_byte  = store_rdata;
            rsp_in.last       = cmd_ff.run_last;
            rsp_valid_in      = 1'b1;
            state_in          = pgalloc_pkg::S_IDLE;
         end
         pgalloc_pkg::S_SCAN: begin
            rsp_in.alloc_page = '0;
            rsp_in.read_byte  = '0;
            rsp_in.last       = cmd_ff.run_last;
            if (pend_ff && !map_rdata) begin
               map_req.wr_en     = 1'b1;
               map_req.wr_addr   = pend_page_ff;
               map_req.wr_data   = 1'b1;
               ptr_in            = pend_page_ff;
               rsp_in.status     = pgalloc_pkg::ST_OK;
               rsp_in.alloc_page = pgalloc_pkg::PAGE_ID_W'(pend_page_ff);
               rsp_valid_in      = 1'b1;
               state_in          = pgalloc_pkg::S_IDLE;
            end else if (pend_ff &&
                         checked_ff == pgalloc_pkg::CNT_W'(pgalloc_pkg::NUM_PAGES - 1)) begin
               rsp_in.status = pgalloc_pkg::ST_NO_FREE;
               rsp_valid_in  = 1'b1;
               state_in      = pgalloc_pkg::S_IDLE;
            end else begin
               if (pend_ff) begin
                  checked_in = checked_ff + 1'b1;
               end
               if (issued_ff != pgalloc_pkg::CNT_W'(pgalloc_pkg::NUM_PAGES)) begin
                  map_req.rd_en   = 1'b1;
                  map_req.rd_addr = probe_ff;
                  pend_in         = 1'b1;
                  pend_page_in    = probe_ff;
                  probe_in        = next_page(probe_ff);
                  issued_in       = issued_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = pgalloc_pkg::S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != pgalloc_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* hdl/page_allocator_clock_scan.sv */
// Next-fit page allocator with a byte-addressed page store.
// A command beat is taken at a rising edge where start is high and busy is low;
// its fields (allocate, free, read byte, write byte) arrive on req_item.
// Every command yields exactly one result beat on rsp_item, marked by rsp_valid
// for a single cycle. The receiver cannot stall, so the result is simply shown
// once; a new command may be taken in the same cycle that the result is shown.
// Free and write results come from a bitmap lookup; reads add a store read
// after the lookup. Allocate scans the used-page bitmap one page per cycle
// from the search pointer, with the bitmap read registered so that each page
// is checked in the cycle after its read; the scan runs on the single bitmap
// read port. Commands are handled one at a time, so no two accesses to the
// same bitmap entry or store byte ever overlap.
// After reset the bitmap is cleared by a pass over every entry, during which
// busy stays high. The byte store is not cleared: a byte must be written
// before it is read.
module page_allocator_clock_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pgalloc_pkg::req_type  req_item,
   output logic                  rsp_valid,
   output pgalloc_pkg::rsp_type  rsp_item
);

   pgalloc_pkg::map_req_type       map_req;
   pgalloc_pkg::store_req_type     store_req;
   logic                           map_rdata;
   logic [pgalloc_pkg::BYTE_W-1:0] store_rdata;

   pgalloc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_item    (req_item),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .map_req     (map_req),
      .map_rdata   (map_rdata),
      .store_req   (store_req),
      .store_rdata (store_rdata)
   );

   pgalloc_map u_map (
      .clock   (clock),
      .map_req (map_req),
      .rd_data (map_rdata)
   );

   pgalloc_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (store_rdata)
   );

   // A result beat is never followed directly by another one.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result beats in a row");

   // A result is shown only once the block is ready for the next command.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // An accepted command always keeps the block busy for the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted command did not start work");

   // The bitmap and the store are never written in the same cycle.
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(map_req.wr_en && store_req.en && store_req.we))
      else $error("bitmap and store written together");

endmodule

/* tb/page_allocator_clock_scan_test.sv */
module page_allocator_clock_scan_test;
   timeunit 1ns;
   timeprecision 1ps;

   // The slowest correct run is about 1700 commands, each a full scan behind a
   // long sender gap, plus the bitmap clear after reset. That stays well inside
   // CYCLE_LIMIT, so the watchdog leaves ample room.
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_ITEMS = 545;
   localparam int PRINT_CAP = 40;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   pgalloc_pkg::req_type req_item = '0;
   logic                 rsp_valid;
   pgalloc_pkg::rsp_type rsp_item;

   page_allocator_clock_scan uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Command beats waiting to be sent, and result beats still owed by the block.
   pgalloc_pkg::req_type pending_cmds[$];
   pgalloc_pkg::rsp_type owed_results[$];

   // Sender gap probability in percent, changed between phases.
   int send_gap_pct = 11;
   int mismatches = 0;
   int cycle_count = 0;
   logic beat_taken = 1'b0;

   // Allocator state as the block should hold it, advanced as each command
   // beat is taken. The byte store is sparse: only written bytes exist.
   logic [pgalloc_pkg::NUM_PAGES-1:0] page_used = '0;
   int                                scan_ptr = 0;
   logic [pgalloc_pkg::BYTE_W-1:0]    byte_store [int];

   // A second copy of the bitmap and pointer, advanced as commands are queued.
   // The stimulus needs it to know which pages are in use and which bytes have
   // been written, so that it never reads a byte nobody ever wrote.
   logic [pgalloc_pkg::NUM_PAGES-1:0] plan_used = '0;
   int                                plan_ptr = 0;
   int                                written_offs[pgalloc_pkg::NUM_PAGES][$];

   initial begin
      forever #2 clock = ~clock;
   end

   // Next-fit search: the first free page at or after the pointer, wrapping
   // around the bitmap once. Returns -1 when every page is in use.
   function automatic int next_free(logic [pgalloc_pkg::NUM_PAGES-1:0] map, int from);
      int p;
      for (int n = 0; n < pgalloc_pkg::NUM_PAGES; n++) begin
         p = (from + n) % pgalloc_pkg::NUM_PAGES;
         if (!map[p])
            return p;
      end
      return -1;
   endfunction

   // Applies one command to the expected state and returns the result beat
   // that the block must produce for it.
   function automatic pgalloc_pkg::rsp_type serve_cmd(pgalloc_pkg::req_type r);
      pgalloc_pkg::rsp_type o;
      int      p;
      int      key;
      o = '0;
      o.status = pgalloc_pkg::ST_OK;
      o.last = r.run_last;
      key = int'(r.page_id) * pgalloc_pkg::PAGE_BYTES
            + int'(r.offset) % pgalloc_pkg::PAGE_BYTES;
      if (r.cmd == pgalloc_pkg::CMD_ALLOC) begin
         p = next_free(page_used, scan_ptr);
         if (p < 0) begin
            o.status = pgalloc_pkg::ST_NO_FREE;
         end else begin
            page_used[p] = 1'b1;
            scan_ptr = p;
            o.alloc_page = pgalloc_pkg::PAGE_ID_W'(p);
         end
      end else if (int'(r.page_id) >= pgalloc_pkg::NUM_PAGES || !page_used[r.page_id]) begin
         o.status = pgalloc_pkg::ST_NOT_ALLOC;
      end else begin
         case (r.cmd)
            pgalloc_pkg::CMD_FREE: begin
               page_used[r.page_id] = 1'b0;
            end
            pgalloc_pkg::CMD_READ: begin
               if (byte_store.exists(key))
                  o.read_byte = byte_store[key];
            end
            default: begin
               byte_store[key] = r.write_byte;
            end
         endcase
      end
      return o;
   endfunction

   // Queues one command beat and advances the stimulus-side bitmap with it.
   task automatic add_cmd(pgalloc_pkg::cmd_type c, int page, int off, int data, bit fin);
      pgalloc_pkg::req_type r;
      int      p;
      r.cmd = c;
      r.page_id = pgalloc_pkg::PAGE_ID_W'(page);
      r.offset = pgalloc_pkg::OFFSET_W'(off);
      r.write_byte = pgalloc_pkg::BYTE_W'(data);
      r.run_last = fin;
      case (c)
         pgalloc_pkg::CMD_ALLOC: begin
            p = next_free(plan_used, plan_ptr);
            if (p >= 0) begin
               plan_used[p] = 1'b1;
               plan_ptr = p;
            end
         end
         pgalloc_pkg::CMD_FREE: begin
            plan_used[page] = 1'b0;
         end
         pgalloc_pkg::CMD_WRITE: begin
            if (plan_used[page])
               written_offs[page].push_back(off % pgalloc_pkg::PAGE_BYTES);
         end
         default: ;
      endcase
      pending_cmds.push_back(r);
   endtask

   // One random command. The mode leans the mix toward filling the bitmap,
   // draining it, or byte traffic. Most commands address a page in use; the
   // rest hit any page and so exercise the not-allocated path.
   task automatic add_random(int mode);
      int      roll, page, off;
      int      w_alloc, w_free, w_write;
      int      in_use[$];
      pgalloc_pkg::cmd_type c;
      case (mode)
         0: begin w_alloc = 75; w_free = 5;  w_write = 12; end
         1: begin w_alloc = 10; w_free = 50; w_write = 20; end
         default: begin w_alloc = 10; w_free = 10; w_write = 40; end
      endcase
      roll = $urandom_range(99);
      if (roll < w_alloc)
         c = pgalloc_pkg::CMD_ALLOC;
      else if (roll < w_alloc + w_free)
         c = pgalloc_pkg::CMD_FREE;
      else if (roll < w_alloc + w_free + w_write)
         c = pgalloc_pkg::CMD_WRITE;
      else
         c = pgalloc_pkg::CMD_READ;
      for (int p = 0; p < pgalloc_pkg::NUM_PAGES; p++)
         if (plan_used[p])
            in_use.push_back(p);
      if (in_use.size() > 0 && $urandom_range(99) < 85)
         page = in_use[$urandom_range(in_use.size() - 1)];
      else
         page = $urandom_range(pgalloc_pkg::NUM_PAGES - 1);
      off = $urandom_range(pgalloc_pkg::PAGE_BYTES - 1);
      // A read of a page in use must hit a byte that was written at some point,
      // possibly before the page was last freed. If none exists, write instead.
      if (c == pgalloc_pkg::CMD_READ && plan_used[page]) begin
         if (written_offs[page].size() == 0)
            c = pgalloc_pkg::CMD_WRITE;
         else
            off = written_offs[page][$urandom_range(written_offs[page].size() - 1)];
      end
      add_cmd(c, page, off, int'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   // Each phase opens with a long fill burst so that the bitmap runs full and
   // allocate reports no free page, then wanders between random modes.
   task automatic build_phase(int count);
      int mode;
      int left;
      mode = 0;
      left = 100;
      for (int i = 0; i < count; i++) begin
         if (left == 0) begin
            mode = $urandom_range(2);
            left = $urandom_range(30, 120);
         end
         add_random(mode);
         left--;
      end
   endtask

   task automatic wait_idle();
      while (pending_cmds.size() != 0 || owed_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic report(string what, logic [7:0] want, logic [7:0] got);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endtask

   // Driver. Inputs move only on the falling edge. A beat that was offered and
   // not yet taken stays on the port; once a beat is taken the next one is
   // offered unless the sender chooses to leave a gap this cycle.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (beat_taken)
            void'(pending_cmds.pop_front());
         if (start && !beat_taken) begin
            // Hold the beat until the block takes it.
         end else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
            start <= 1'b1;
            req_item <= pending_cmds[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor. On each rising edge a result beat is checked against the oldest
   // owed result, and a command beat taken at this edge is run through the
   // prediction. The check comes first; a result for a command taken at the
   // same edge cannot appear, as the block must first pass its lookup or scan.
   always @(posedge clock) begin
      pgalloc_pkg::rsp_type want;
      if (reset) begin
         beat_taken <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (owed_results.size() == 0) begin
               mismatches++;
               if (mismatches <= PRINT_CAP)
                  $display("%0t ns: result beat with none expected, actual %p", $time, rsp_item);
            end else begin
               want = owed_results.pop_front();
               if (rsp_item.status !== want.status)
                  report("status", 8'(want.status), 8'(rsp_item.status));
               if (rsp_item.alloc_page !== want.alloc_page)
                  report("alloc_page", 8'(want.alloc_page), 8'(rsp_item.alloc_page));
               if (rsp_item.read_byte !== want.read_byte)
                  report("read_byte", want.read_byte, rsp_item.read_byte);
               if (rsp_item.last !== want.last)
                  report("last", 8'(want.last), 8'(rsp_item.last));
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            owed_results.push_back(serve_cmd(req_item));
         beat_taken <= (start === 1'b1 && busy === 1'b0);
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      // Directed opening. Allocate from reset starts at page zero; the unused
      // fields of the allocate beats carry their extremes.
      add_cmd(pgalloc_pkg::CMD_ALLOC, 63, 4095, 255, 1'b1);
      add_cmd(pgalloc_pkg::CMD_ALLOC, 0, 0, 0, 1'b0);
      // Bytes at both ends of a page, with data and last at both extremes.
      add_cmd(pgalloc_pkg::CMD_WRITE, 0, 0, 0, 1'b0);
      add_cmd(pgalloc_pkg::CMD_WRITE, 0, 4095, 255, 1'b1);
      add_cmd(pgalloc_pkg::CMD_READ, 0, 0, 255, 1'b0);
      add_cmd(pgalloc_pkg::CMD_READ, 0, 4095, 0, 1'b1);
      add_cmd(pgalloc_pkg::CMD_WRITE, 1, 'hAAA, 'h55, 1'b1);
      add_cmd(pgalloc_pkg::CMD_READ, 1, 'hAAA, 'hAA, 1'b0);
      // Every command on a page that was never allocated reports not allocated,
      // and a write there must leave the store alone.
      add_cmd(pgalloc_pkg::CMD_READ, 63, 'h555, 0, 1'b1);
      add_cmd(pgalloc_pkg::CMD_WRITE, 63, 'h555, 'hAA, 1'b0);
      add_cmd(pgalloc_pkg::CMD_FREE, 40, 0, 0, 1'b0);
      // Free, then every access to the freed page fails, a second free too.
      add_cmd(pgalloc_pkg::CMD_FREE, 0, 0, 0, 1'b1);
      add_cmd(pgalloc_pkg::CMD_READ, 0, 0, 0, 1'b0);
      add_cmd(pgalloc_pkg::CMD_FREE, 0, 0, 0, 1'b0);
      // The pointer rests on page one, so the next grants are two and three,
      // and the hole left at page zero is skipped until the search wraps.
      add_cmd(pgalloc_pkg::CMD_ALLOC, 0, 0, 0, 1'b0);
      add_cmd(pgalloc_pkg::CMD_ALLOC, 0, 0, 0, 1'b1);
      add_cmd(pgalloc_pkg::CMD_FREE, 1, 0, 0, 1'b0);

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Phase one: the sender leaves occasional gaps.
      build_phase(PHASE_ITEMS);
      wait_idle();
      // Phase two: the sender is mostly silent, so gaps land on every step of
      // a scan and on the cycle a result appears.
      send_gap_pct = 75;
      build_phase(PHASE_ITEMS);
      wait_idle();
      // Phase three: back-to-back command beats.
      send_gap_pct = 0;
      build_phase(PHASE_ITEMS);
      wait_idle();

      // Any stray result beat after the last one owed is caught meanwhile.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
